// ----- hw/rtl/tamb_pkg.sv -----
// Shared types and constants for the tree ancestor mask builder.
// Used by tamb_row_calc and tree_ancestor_mask_builder; no dependencies.
`timescale 1ns / 1ps

package tamb_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TOKEN_W  = 31;
  localparam int unsigned PARENT_W = 6;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned LEN_W    = 7;

  localparam logic [LEN_W-1:0] TREE_LENGTH_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_NODE  = 2'd1,
    OP_END   = 2'd2
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 2'd0,
    ERR_PARENT = 2'd1,
    ERR_LENGTH = 2'd2
  } err_e;

  typedef enum logic {
    REG_TREE_LENGTH = 1'b0
  } reg_e;

  typedef struct packed {
    op_e                 op;
    logic [TOKEN_W-1:0]  token;
    logic [PARENT_W-1:0] parent;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic [TOKEN_W-1:0] row_token;
    logic [MASK_W-1:0]  mask_row;
    logic               last;
    err_e               error;
  } result_t;

  typedef struct packed {
    result_t            res;
    logic               emit;
    logic               done;
    logic               wr_en;
    logic [CNT_W-1:0]   row_count;
  } calc_t;

endpackage

// ----- hw/rtl/tamb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write; no dependencies.
`timescale 1ns / 1ps

module tamb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tamb_row_calc.sv -----
// Row computation for one held item: checks, mask build, store write and count.
// Depends on tamb_pkg.
`timescale 1ns / 1ps

module tamb_row_calc #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  tamb_pkg::item_t                 item_i,
  input  logic [MAX_ROWS-1:0]             parent_mask_i,
  input  logic [tamb_pkg::CNT_W-1:0]      row_count_i,
  input  logic [tamb_pkg::LEN_W-1:0]      len_i,
  output tamb_pkg::calc_t                 calc_o,
  output logic [$clog2(MAX_ROWS)-1:0]     wr_addr_o,
  output logic [MAX_ROWS-1:0]             wr_data_o
);

  localparam int unsigned AW = $clog2(MAX_ROWS);

  logic [MAX_ROWS-1:0]            own_bit;
  logic [tamb_pkg::CNT_W-1:0]     next_idx;
  logic [tamb_pkg::CNT_W-1:0]     parent_ext;

  assign own_bit    = MAX_ROWS'(1) << row_count_i[AW-1:0];
  assign next_idx   = row_count_i + tamb_pkg::CNT_W'(1);
  assign parent_ext = tamb_pkg::CNT_W'(item_i.parent);
  assign wr_addr_o  = (item_i.op == tamb_pkg::OP_START) ? AW'(0) : row_count_i[AW-1:0];

  always_comb begin
    calc_o               = '0;
    calc_o.res.error     = tamb_pkg::ERR_NONE;
    calc_o.done          = 1'b1;
    calc_o.row_count     = row_count_i;
    wr_data_o            = '0;
    case (item_i.op)
      tamb_pkg::OP_START: begin
        wr_data_o            = MAX_ROWS'(1);
        calc_o.emit          = 1'b1;
        calc_o.wr_en         = 1'b1;
        calc_o.row_count     = tamb_pkg::CNT_W'(1);
        calc_o.res.row_token = item_i.token;
        calc_o.res.mask_row  = tamb_pkg::MASK_W'(1);
        calc_o.res.last      = (len_i == tamb_pkg::LEN_W'(1));
      end
      tamb_pkg::OP_NODE: begin
        calc_o.emit = 1'b1;
        if (row_count_i >= len_i) begin
          calc_o.res.error = tamb_pkg::ERR_LENGTH;
        end else if (parent_ext >= row_count_i) begin
          calc_o.res.error = tamb_pkg::ERR_PARENT;
        end else begin
          wr_data_o            = parent_mask_i | own_bit;
          calc_o.wr_en         = 1'b1;
          calc_o.row_count     = next_idx;
          calc_o.res.row_index = row_count_i[tamb_pkg::IDX_W-1:0];
          calc_o.res.row_token = item_i.token;
          calc_o.res.mask_row  = tamb_pkg::MASK_W'(parent_mask_i | own_bit);
          calc_o.res.last      = (next_idx == len_i);
        end
      end
      tamb_pkg::OP_END: begin
        if (row_count_i < len_i) begin
          wr_data_o            = MAX_ROWS'(1) | own_bit;
          calc_o.emit          = 1'b1;
          calc_o.wr_en         = 1'b1;
          calc_o.row_count     = next_idx;
          calc_o.done          = (next_idx == len_i);
          calc_o.res.row_index = row_count_i[tamb_pkg::IDX_W-1:0];
          calc_o.res.mask_row  = tamb_pkg::MASK_W'(MAX_ROWS'(1) | own_bit);
          calc_o.res.last      = (next_idx == len_i);
        end
      end
      default: begin
        calc_o.done = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tree_ancestor_mask_builder.sv -----
// Top level of the tree ancestor mask builder: channels, config register, pipeline.
// Depends on tamb_pkg, tamb_ram and tamb_row_calc.
//
// Usage: configure tree_length over APB (byte address 0, bits 6:0) while idle.
// The input stream carries op in s_axis_tuser and {parent, token} in
// s_axis_tdata. A start transaction yields row 0; each node transaction yields
// one row or one error row (m_axis_tuser nonzero); an end transaction yields
// the padding rows up to the configured length, one per cycle; op 3 and an end
// on a full tree yield nothing. m_axis_tlast marks the row with index L-1.
// An accepted item passes the row stage, then the output register. While the
// output does not stall, throughput is one transaction per cycle for start and
// node items; an end item holds the row stage until its padding rows are out.
// The parent row read comes from the mask RAM at accept time, with a bypass for
// the row written in the same cycle, so nodes may chain back to back.
// Reset empties the pipeline, clears the row count and sets tree_length to 64;
// the mask RAM needs no clearing. When the receiver stalls, the output register
// holds its row and the row stage and input side stall behind it.
`timescale 1ns / 1ps

module tree_ancestor_mask_builder #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // token[30:0], parent[36:31], zero pad
  input  logic [1:0]   s_axis_tuser,  // op[1:0]
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // row_index[5:0], row_token[36:6], mask_row[100:37]
  output logic         m_axis_tlast,  // last
  output logic [1:0]   m_axis_tuser   // error[1:0]
);

  localparam int unsigned AW = $clog2(MAX_ROWS);

  logic [tamb_pkg::LEN_W-1:0] tree_length_q, tree_length_d;
  logic [tamb_pkg::LEN_W-1:0] len;
  logic                       cfg_write;

  logic                       s1_valid_q, s1_valid_d;
  tamb_pkg::item_t            s1_item_q, s1_item_d, in_item;
  logic                       byp_hit_q, byp_hit_d;
  logic [MAX_ROWS-1:0]        byp_data_q, byp_data_d;
  logic [tamb_pkg::CNT_W-1:0] row_count_q, row_count_d;
  logic                       out_valid_q, out_valid_d;
  tamb_pkg::result_t          out_res_q, out_res_d;

  logic                       advance, s1_fire, accept, wr_en;
  logic [MAX_ROWS-1:0]        ram_rdata, parent_mask, wr_data;
  logic [AW-1:0]              wr_addr;
  tamb_pkg::calc_t            calc;

  // config register
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready &
                     (paddr[2] == tamb_pkg::REG_TREE_LENGTH);
  assign tree_length_d = cfg_write ? pwdata[tamb_pkg::LEN_W-1:0] : tree_length_q;
  assign prdata = (paddr[2] == tamb_pkg::REG_TREE_LENGTH) ?
                  32'(tree_length_q) : 32'd0;

  always_comb begin
    if (tree_length_q == '0) begin
      len = tamb_pkg::LEN_W'(1);
    end else if (tree_length_q > tamb_pkg::LEN_W'(MAX_ROWS)) begin
      len = tamb_pkg::LEN_W'(MAX_ROWS);
    end else begin
      len = tree_length_q;
    end
  end

  // handshake
  assign in_item.op     = tamb_pkg::op_e'(s_axis_tuser);
  assign in_item.token  = s_axis_tdata[30:0];
  assign in_item.parent = s_axis_tdata[36:31];

  assign advance       = ~out_valid_q | m_axis_tready;
  assign s1_fire       = s1_valid_q & advance;
  assign s_axis_tready = ~s1_valid_q | (advance & calc.done);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign wr_en         = s1_fire & calc.wr_en;

  tamb_ram #(
    .WIDTH (MAX_ROWS),
    .DEPTH (MAX_ROWS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (in_item.parent[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign parent_mask = byp_hit_q ? byp_data_q : ram_rdata;

  tamb_row_calc #(
    .MAX_ROWS (MAX_ROWS)
  ) u_row_calc (
    .item_i        (s1_item_q),
    .parent_mask_i (parent_mask),
    .row_count_i   (row_count_q),
    .len_i         (len),
    .calc_o        (calc),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_item_d   = s1_item_q;
    byp_hit_d   = byp_hit_q;
    byp_data_d  = byp_data_q;
    row_count_d = row_count_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (s1_fire) begin
      row_count_d = calc.row_count;
      if (calc.done) begin
        s1_valid_d = 1'b0;
      end
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_item_d  = in_item;
      // row written this cycle is not yet visible through the ram read
      byp_hit_d  = wr_en & (wr_addr == in_item.parent[AW-1:0]);
      byp_data_d = wr_data;
    end
    if (advance) begin
      out_valid_d = s1_valid_q & calc.emit;
      if (s1_valid_q & calc.emit) begin
        out_res_d = calc.res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_length_q <= tamb_pkg::TREE_LENGTH_RESET;
      s1_valid_q    <= 1'b0;
      byp_hit_q     <= 1'b0;
      row_count_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      tree_length_q <= tree_length_d;
      s1_valid_q    <= s1_valid_d;
      byp_hit_q     <= byp_hit_d;
      row_count_q   <= row_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q  <= s1_item_d;
    byp_data_q <= byp_data_d;
    out_res_q  <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.mask_row, out_res_q.row_token,
                          out_res_q.row_index};
  assign m_axis_tlast  = out_res_q.last;
  assign m_axis_tuser  = out_res_q.error;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for tree_ancestor_mask_builder: stream driver, row checker,
// built-in ancestor mask predictor and config writes over the APB port.
// Depends on tamb_pkg and the RTL of tree_ancestor_mask_builder.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ROWS      = 64;
  localparam int unsigned SETTLE    = 8;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned QUIET_MAX = 2000;
  localparam logic [tamb_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [2:0]   paddr   = '0;
  logic [31:0]  pwdata  = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;  // token[30:0], parent[36:31], zero pad
  logic [1:0]   s_axis_tuser = '0;  // op[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;       // row_index[5:0], row_token[36:6], mask_row[100:37]
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;       // error[1:0]

  tamb_pkg::item_t             item_backlog[$];
  tamb_pkg::result_t           rows_due[$];
  tamb_pkg::item_t             on_bus;
  logic [tamb_pkg::LEN_W-1:0]  tree_len_q = tamb_pkg::TREE_LENGTH_RESET;
  logic [tamb_pkg::MASK_W-1:0] anc_mask[ROWS];
  int unsigned       row_cnt = 0;
  int unsigned       mismatches = 0;
  int unsigned       src_gap, sink_gap, hold_cnt, quiet = 0;
  logic              calm = 1'b0;
  logic              hold_armed = 1'b0;
  logic              hold_done;

  tree_ancestor_mask_builder #(
    .MAX_ROWS(ROWS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned clamp_len(input logic [tamb_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > ROWS) return ROWS;
    return v;
  endfunction

  // rows that one accepted transaction must produce
  function automatic void build_rows(input tamb_pkg::item_t it);
    int unsigned len;
    tamb_pkg::result_t r;
    len = clamp_len(tree_len_q);
    r = '0;
    case (it.op)
      tamb_pkg::OP_START: begin
        anc_mask[0] = 64'd1;
        row_cnt = 1;
        r.row_token = it.token;
        r.mask_row = 64'd1;
        r.last = (len == 1);
        rows_due.insert(rows_due.size(), r);
      end
      tamb_pkg::OP_NODE: begin
        if (row_cnt >= len) begin
          r.error = tamb_pkg::ERR_LENGTH;
          rows_due.insert(rows_due.size(), r);
        end else if (it.parent >= row_cnt) begin
          r.error = tamb_pkg::ERR_PARENT;
          rows_due.insert(rows_due.size(), r);
        end else begin
          anc_mask[row_cnt] = anc_mask[it.parent] | (64'd1 << row_cnt);
          r.row_index = tamb_pkg::IDX_W'(row_cnt);
          r.row_token = it.token;
          r.mask_row = anc_mask[row_cnt];
          r.last = (row_cnt + 1 == len);
          r.error = tamb_pkg::ERR_NONE;
          rows_due.insert(rows_due.size(), r);
          row_cnt++;
        end
      end
      tamb_pkg::OP_END: begin
        for (int unsigned i = row_cnt; i < len; i++) begin
          anc_mask[i] = 64'd1 | (64'd1 << i);
          r.row_index = tamb_pkg::IDX_W'(i);
          r.row_token = '0;
          r.mask_row = anc_mask[i];
          r.last = (i + 1 == len);
          r.error = tamb_pkg::ERR_NONE;
          rows_due.insert(rows_due.size(), r);
        end
        if (row_cnt < len) row_cnt = len;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_row_error(input string field, input logic [63:0] got,
                                input logic [63:0] want);
    $display("mismatch in %s at %0t ns: got %h, want %h", field, $realtime, got, want);
    mismatches++;
  endtask

  task automatic check_row();
    tamb_pkg::result_t want;
    if (rows_due.size() == 0) begin
      flag_row_error("row with none due", 64'(m_axis_tdata[5:0]), '0);
      return;
    end
    want = rows_due.pop_front();
    if (m_axis_tdata[5:0] !== want.row_index)
      flag_row_error("row_index", 64'(m_axis_tdata[5:0]), 64'(want.row_index));
    if (m_axis_tdata[36:6] !== want.row_token)
      flag_row_error("row_token", 64'(m_axis_tdata[36:6]), 64'(want.row_token));
    if (m_axis_tdata[100:37] !== want.mask_row)
      flag_row_error("mask_row", m_axis_tdata[100:37], want.mask_row);
    if (m_axis_tlast !== want.last)
      flag_row_error("last", 64'(m_axis_tlast), 64'(want.last));
    if (m_axis_tuser !== want.error)
      flag_row_error("error", 64'(m_axis_tuser), 64'(want.error));
  endtask

  // input stream driver
  always @(posedge clk_i or negedge rst_ni) begin : feed
    tamb_pkg::item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) build_rows(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 16);
          s_axis_tvalid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          nxt = item_backlog.pop_front();
          on_bus <= nxt;
          s_axis_tdata <= {3'b000, nxt.parent, nxt.token};
          s_axis_tuser <= nxt.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output stream sink and checker
  always @(posedge clk_i or negedge rst_ni) begin : sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_row();
      if (hold_armed && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_MAX) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(input tamb_pkg::op_e op, input logic [tamb_pkg::TOKEN_W-1:0] tok,
                      input logic [tamb_pkg::PARENT_W-1:0] par);
    tamb_pkg::item_t it;
    it.op = op;
    it.token = tok;
    it.parent = par;
    item_backlog.insert(item_backlog.size(), it);
  endtask

  task automatic set_tree_length(input logic [tamb_pkg::LEN_W-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(tamb_pkg::REG_TREE_LENGTH));
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tree_len_q = v;
    @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (item_backlog.size() != 0 || s_axis_tvalid || rows_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // start, a run of nodes with mostly good parents, then usually an end
  task automatic grow_tree(input int unsigned nodes, input int unsigned len);
    int unsigned rows;
    send(tamb_pkg::OP_START, tamb_pkg::TOKEN_W'($urandom), tamb_pkg::PARENT_W'($urandom));
    rows = 1;
    repeat (nodes) begin
      if (rows < ROWS && $urandom_range(0, 9) == 0) begin
        send(tamb_pkg::OP_NODE, tamb_pkg::TOKEN_W'($urandom),
             tamb_pkg::PARENT_W'($urandom_range(rows, ROWS - 1)));
      end else begin
        send(tamb_pkg::OP_NODE, tamb_pkg::TOKEN_W'($urandom),
             tamb_pkg::PARENT_W'($urandom_range(0, rows - 1)));
        if (rows < len) rows++;
      end
      if ($urandom_range(0, 15) == 0)
        send(tamb_pkg::op_e'(OP_SPARE), tamb_pkg::TOKEN_W'($urandom),
             tamb_pkg::PARENT_W'($urandom));
    end
    if ($urandom_range(0, 4) != 0)
      send(tamb_pkg::OP_END, tamb_pkg::TOKEN_W'($urandom), tamb_pkg::PARENT_W'($urandom));
    if ($urandom_range(0, 7) == 0)
      send(tamb_pkg::OP_END, tamb_pkg::TOKEN_W'($urandom), tamb_pkg::PARENT_W'($urandom));
  endtask

  task automatic random_phase(input logic [tamb_pkg::LEN_W-1:0] len, input int budget);
    int unsigned span, n;
    set_tree_length(len);
    while (budget > 0) begin
      span = clamp_len(len) + 1;
      if (span > 10) span = 10;
      n = $urandom_range(0, span);
      grow_tree(n, clamp_len(len));
      budget -= n + 2;
    end
    drain();
  endtask

  initial begin : stimulus
    logic [tamb_pkg::LEN_W-1:0] len_plan[6];
    len_plan = '{7'd127, 7'd2, 7'd5, 7'd0, 7'd100, 7'd33};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default length: node and end before any start, full tree, restart mid-tree
    send(tamb_pkg::OP_NODE, 31'h7fffffff, 6'd0);
    send(tamb_pkg::OP_END, 31'd0, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h2aaaaaaa, 6'd63);
    send(tamb_pkg::OP_END, 31'h7fffffff, 6'd63);
    send(tamb_pkg::op_e'(OP_SPARE), 31'h55555555, 6'd21);
    send(tamb_pkg::OP_START, 31'h7fffffff, 6'd0);
    send(tamb_pkg::OP_NODE, 31'd0, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h7fffffff, 6'd1);
    send(tamb_pkg::OP_NODE, 31'h1234567, 6'd5);
    send(tamb_pkg::OP_NODE, 31'h7654321, 6'd2);
    send(tamb_pkg::OP_START, 31'd0, 6'd63);
    send(tamb_pkg::OP_NODE, 31'h3c3c3c3c, 6'd0);
    send(tamb_pkg::OP_END, 31'd0, 6'd0);
    drain();

    // single-row trees
    set_tree_length(7'd1);
    send(tamb_pkg::OP_START, 31'h0f0f0f0f, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h70f0f0f0, 6'd0);
    send(tamb_pkg::OP_END, 31'd0, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h1, 6'd63);
    drain();

    // length lowered below a partly built tree
    set_tree_length(7'd20);
    send(tamb_pkg::OP_START, 31'h11111111, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h22222222, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h33333333, 6'd1);
    send(tamb_pkg::OP_NODE, 31'h44444444, 6'd2);
    send(tamb_pkg::OP_NODE, 31'h55555555, 6'd3);
    drain();
    set_tree_length(7'd3);
    send(tamb_pkg::OP_END, 31'd0, 6'd0);
    send(tamb_pkg::OP_NODE, 31'h66666666, 6'd0);
    drain();

    set_tree_length(7'd0);
    send(tamb_pkg::OP_START, 31'h7ffffffe, 6'd0);
    send(tamb_pkg::OP_END, 31'd0, 6'd0);
    drain();

    foreach (len_plan[k]) random_phase(len_plan[k], 8);

    // full-size tree while the sink holds off for a long stretch
    set_tree_length(7'd64);
    hold_armed = 1'b1;
    grow_tree(63, ROWS);
    drain();

    calm = 1'b1;
    random_phase(tamb_pkg::LEN_W'($urandom_range(1, ROWS)), 14);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
